// ===== rtl/core/button_press_duration_classifier_assert.svh =====
// assertion macros used by the classifier rtl
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH

// plain property check, clocked on clk_i, off while rst_ni is low
`define BPDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BPDC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPDC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bpdc_pkg.sv =====
// types, codes and reset constants of the button press classifier
package bpdc_pkg;

  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned DebWidth     = 16;
  localparam int unsigned LongWidth    = 20;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 20;

  localparam logic [DebWidth-1:0]  DebounceRst = 16'd10;
  localparam logic [LongWidth-1:0] LongRst     = 20'd500;
  localparam logic [LongWidth-1:0] VLongRst    = 20'd5000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_VLONG    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_WAIT_RELEASE = 4'b0001,
    PH_IDLE         = 4'b0010,
    PH_HELD         = 4'b0100,
    PH_DEBOUNCE     = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_VLONG = 2'd3
  } kind_e;

  typedef struct packed {
    logic [DebWidth-1:0]  debounce_ms;
    logic [LongWidth-1:0] long_ms;
    logic [LongWidth-1:0] very_long_ms;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    kind_e  reported;
  } ctl_t;

endpackage

// ===== rtl/core/bpdc_cfg_regs.sv =====
// threshold registers written through the plain write port
module bpdc_cfg_regs
  import bpdc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_d.debounce_ms  = cfg_wdata_i[DebWidth-1:0];
        CFG_LONG:     cfg_d.long_ms      = cfg_wdata_i[LongWidth-1:0];
        CFG_VLONG:    cfg_d.very_long_ms = cfg_wdata_i[LongWidth-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= DebounceRst;
      cfg_q.long_ms      <= LongRst;
      cfg_q.very_long_ms <= VLongRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bpdc_elapsed.sv =====
// modular elapsed time, read as signed, compared against a threshold
module bpdc_elapsed
  import bpdc_pkg::*;
#(
  parameter int unsigned TimeWidth = TimeWidthDef
) (
  input  logic [TimeWidth-1:0] now_i,
  input  logic [TimeWidth-1:0] then_i,
  input  logic [LongWidth-1:0] limit_i,
  output logic                 over_o
);

  localparam int unsigned CmpWidth = (TimeWidth > LongWidth) ? TimeWidth : LongWidth;

  logic [TimeWidth-1:0] diff;
  logic [CmpWidth-1:0]  diff_ext;
  logic [CmpWidth-1:0]  limit_ext;

  assign diff      = now_i - then_i;
  assign diff_ext  = CmpWidth'(diff);
  assign limit_ext = CmpWidth'(limit_i);
  // negative elapsed time never counts as over
  assign over_o    = !diff[TimeWidth-1] && (diff_ext > limit_ext);

endmodule

// ===== rtl/core/bpdc_step.sv =====
// next state and event for one poll
module bpdc_step
  import bpdc_pkg::*;
#(
  parameter int unsigned TimeWidth = TimeWidthDef
) (
  input  cfg_t                 cfg_i,
  input  ctl_t                 ctl_i,
  input  logic [TimeWidth-1:0] press_time_i,
  input  logic [TimeWidth-1:0] release_time_i,
  input  logic                 pressed_i,
  input  logic [NowWidth-1:0]  now_ms_i,
  output ctl_t                 ctl_o,
  output logic [TimeWidth-1:0] press_time_o,
  output logic [TimeWidth-1:0] release_time_o,
  output kind_e                ev_o
);

  logic [TimeWidth-1:0] now_t;
  logic                 deb_over, long_over, vlong_over;
  logic                 hold_check;
  kind_e                rep_mid;

  if (TimeWidth <= NowWidth) begin : g_now_cut
    assign now_t = now_ms_i[TimeWidth-1:0];
  end else begin : g_now_ext
    assign now_t = {{(TimeWidth-NowWidth){1'b0}}, now_ms_i};
  end

  bpdc_elapsed #(.TimeWidth(TimeWidth)) u_deb (
    .now_i   (now_t),
    .then_i  (release_time_i),
    .limit_i (LongWidth'(cfg_i.debounce_ms)),
    .over_o  (deb_over)
  );

  bpdc_elapsed #(.TimeWidth(TimeWidth)) u_long (
    .now_i   (now_t),
    .then_i  (press_time_i),
    .limit_i (cfg_i.long_ms),
    .over_o  (long_over)
  );

  bpdc_elapsed #(.TimeWidth(TimeWidth)) u_vlong (
    .now_i   (now_t),
    .then_i  (press_time_i),
    .limit_i (cfg_i.very_long_ms),
    .over_o  (vlong_over)
  );

  always_comb begin
    ctl_o          = ctl_i;
    press_time_o   = press_time_i;
    release_time_o = release_time_i;
    ev_o           = EV_NONE;
    hold_check     = 1'b0;
    rep_mid        = ctl_i.reported;

    unique case (ctl_i.phase)
      PH_WAIT_RELEASE: begin
        if (!pressed_i) ctl_o.phase = PH_IDLE;
      end
      PH_IDLE: begin
        if (pressed_i) begin
          press_time_o = now_t;
          rep_mid      = EV_NONE;
          ctl_o.phase  = PH_HELD;
        end
      end
      PH_HELD: begin
        if (!pressed_i) begin
          release_time_o = now_t;
          ctl_o.phase    = PH_DEBOUNCE;
        end else begin
          hold_check = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        if (pressed_i) begin
          ctl_o.phase = PH_HELD;
          hold_check  = 1'b1;
        end else if (deb_over) begin
          if (ctl_i.reported == EV_NONE) begin
            rep_mid = EV_SHORT;
            ev_o    = EV_SHORT;
          end
          ctl_o.phase = PH_IDLE;
        end
      end
      default: ctl_o.phase = PH_WAIT_RELEASE;
    endcase

    ctl_o.reported = rep_mid;
    // hold checks only run while held, so rep_mid equals the stored value here
    if (hold_check) begin
      if (rep_mid == EV_NONE && long_over) begin
        ctl_o.reported = EV_LONG;
        ev_o           = EV_LONG;
      end else if (rep_mid == EV_LONG && vlong_over) begin
        ctl_o.reported = EV_VLONG;
        ev_o           = EV_VLONG;
      end
    end
  end

endmodule

// ===== rtl/core/button_press_duration_classifier.sv =====
// top level of the button press duration classifier
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o  | pressed_i, now_ms_i
//  out     | out_valid_o / out_stall_i| event_valid_o, event_kind_o
//  cfg     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained unless a waiting result is stalled
// the item goes into an input register, then one pass of the step logic
// updates the press state and loads the result register
// reset clears the state (wait for release), thresholds go to 10/500/5000 ms
// a stalled result holds; the input register still takes an item while the
// result waits, and in_stall_o rises only when both are full
module button_press_duration_classifier
  import bpdc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // poll items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    pressed_i,
  input  logic [NowWidth-1:0]     now_ms_i,
  // event items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    event_valid_o,
  output logic [1:0]              event_kind_o,
  // threshold writes
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  `include "button_press_duration_classifier_assert.svh"

  cfg_t cfg;

  // input register
  logic                s1_vld_d, s1_vld_q;
  logic                s1_pressed_q;
  logic [NowWidth-1:0] s1_now_q;

  // press state
  ctl_t                  ctl_d, ctl_q;
  logic [TIME_WIDTH-1:0] press_time_d, press_time_q;
  logic [TIME_WIDTH-1:0] release_time_d, release_time_q;
  kind_e                 ev;

  // result register
  logic       out_vld_d, out_vld_q;
  logic [1:0] kind_q;

  logic out_ready, step_fire, in_fire;

  bpdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // result slot is free when empty or being taken this cycle
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign step_fire  = s1_vld_q && out_ready;
  assign in_stall_o = s1_vld_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) s1_vld_d = 1'b1;
    else if (step_fire) s1_vld_d = 1'b0;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step_fire) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  bpdc_step #(.TimeWidth(TIME_WIDTH)) u_step (
    .cfg_i          (cfg),
    .ctl_i          (ctl_q),
    .press_time_i   (press_time_q),
    .release_time_i (release_time_q),
    .pressed_i      (s1_pressed_q),
    .now_ms_i       (s1_now_q),
    .ctl_o          (ctl_d),
    .press_time_o   (press_time_d),
    .release_time_o (release_time_d),
    .ev_o           (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pressed_q <= pressed_i;
      s1_now_q     <= now_ms_i;
    end
    if (step_fire) kind_q <= ev;
  end

  // press state advances once per stepped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase    <= PH_WAIT_RELEASE;
      ctl_q.reported <= EV_NONE;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else if (step_fire) begin
      ctl_q          <= ctl_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_kind_o  = kind_q;
  assign event_valid_o = (kind_q != EV_NONE);

  // stall only when the input register holds an item
  `BPDC_ASSERT_IMPL(a_stall_full, in_stall_o, s1_vld_q, "stall with empty input register")
  // very long only follows a long event of the same press
  `BPDC_ASSERT_IMPL(a_vlong_after_long, step_fire && (ev == EV_VLONG),
                    ctl_q.reported == EV_LONG, "very long without prior long")
  // state moves only when an item is stepped
  `BPDC_ASSERT_NEXT(a_state_hold, !step_fire,
                    $stable(ctl_q) && $stable(press_time_q) && $stable(release_time_q),
                    "state changed without an item")
  // a stepped item always lands in the result register
  `BPDC_ASSERT_NEXT(a_step_result, step_fire, out_vld_q, "stepped item lost")

endmodule
